// ----- rtl/npt_pkg.sv -----
// Package for the nearest point table lookup block.
// Holds table sizes, field widths, the entry type and address helpers.
// Depends on nothing.
package npt_pkg;

    localparam int NUM_COMPOSITIONS  = 2;
    localparam int ENTRIES_PER_TABLE = 1024;

    localparam int STORE_DEPTH = NUM_COMPOSITIONS * ENTRIES_PER_TABLE;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(ENTRIES_PER_TABLE + 1);

    localparam int COMP_W  = 2;
    localparam int PRES_W  = 32;
    localparam int TEMP_W  = 13;
    localparam int MELT_W  = 16;
    localparam int DEPTH_W = 23;
    localparam int FRAC_W  = 16;
    localparam int DIST_W  = PRES_W + 1;

    localparam logic [DEPTH_W-1:0] CUTOFF_RESET = DEPTH_W'(300000);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [PRES_W-1:0] pres;
        logic [TEMP_W-1:0] temp;
        logic [MELT_W-1:0] melt;
    } entry_t;

    typedef struct packed {
        logic              busy;
        logic              found;
        logic [MELT_W-1:0] melt;
    } dist_stat_t;

    function automatic logic [ADDR_W-1:0] table_base(input logic [COMP_W-1:0] comp);
        return ADDR_W'(32'(comp) * ENTRIES_PER_TABLE);
    endfunction

endpackage

// ----- rtl/npt_in_if.sv -----
// Input channel of the lookup block: one load or query word.
// Depends on npt_pkg.
interface npt_in_if
    import npt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [COMP_W-1:0]  load_composition;
    logic [PRES_W-1:0]  pressure;
    logic [TEMP_W-1:0]  temperature;
    logic [MELT_W-1:0]  entry_melt;
    logic [DEPTH_W-1:0] depth;
    logic [FRAC_W-1:0]  fraction_0;
    logic [FRAC_W-1:0]  fraction_1;
    logic [FRAC_W-1:0]  fraction_2;
    logic [FRAC_W-1:0]  fraction_3;

    modport source (
        output valid, opcode, load_composition, pressure, temperature, entry_melt,
               depth, fraction_0, fraction_1, fraction_2, fraction_3,
        input  ready
    );

    modport sink (
        input  valid, opcode, load_composition, pressure, temperature, entry_melt,
               depth, fraction_0, fraction_1, fraction_2, fraction_3,
        output ready
    );
endinterface

// ----- rtl/npt_out_if.sv -----
// Output channel of the lookup block: one result word per input word.
// Depends on npt_pkg.
interface npt_out_if
    import npt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MELT_W-1:0] melt_q16;
    logic              found;
    logic [COMP_W-1:0] chosen_composition;
    logic              table_full;

    modport source (
        output valid, melt_q16, found, chosen_composition, table_full,
        input  ready
    );

    modport sink (
        input  valid, melt_q16, found, chosen_composition, table_full,
        output ready
    );
endinterface

// ----- rtl/npt_store.sv -----
// Entry memory for all composition tables: one write port, one registered read port.
// Depends on npt_pkg.
module npt_store
    import npt_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  entry_t            wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output entry_t            rd_data
);

    entry_t mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data <= mem[raddr];
        end
    end

endmodule

// ----- rtl/npt_dist_unit.sv -----
// Shared distance unit: |dP| + |dT| of one entry per cycle, then a running minimum.
// Depends on npt_pkg.
module npt_dist_unit
    import npt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              ent_vld,
    input  entry_t            ent,
    input  logic [PRES_W-1:0] q_pres,
    input  logic [TEMP_W-1:0] q_temp,
    output dist_stat_t        stat
);

    logic [PRES_W-1:0] dp;
    logic [TEMP_W-1:0] dt;
    logic [DIST_W-1:0] d_next;

    logic              v1_reg;
    logic [DIST_W-1:0] d1_reg;
    logic [MELT_W-1:0] m1_reg;

    logic              found_reg;
    logic [DIST_W-1:0] best_reg;
    logic [MELT_W-1:0] melt_reg;

    always_comb
    begin
        dp     = (ent.pres >= q_pres) ? (ent.pres - q_pres) : (q_pres - ent.pres);
        dt     = (ent.temp >= q_temp) ? (ent.temp - q_temp) : (q_temp - ent.temp);
        d_next = DIST_W'(dp) + DIST_W'(dt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ent_vld;
            if (clear)
            begin
                found_reg <= 1'b0;
            end
            else if (v1_reg && (!found_reg || d1_reg < best_reg))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d1_reg <= d_next;
        m1_reg <= ent.melt;
        if (!clear && v1_reg && (!found_reg || d1_reg < best_reg))
        begin
            best_reg <= d1_reg;
            melt_reg <= m1_reg;
        end
    end

    assign stat.busy  = v1_reg;
    assign stat.found = found_reg;
    assign stat.melt  = melt_reg;

endmodule

// ----- rtl/nearest_pt_table_lookup_core.sv -----
// Nearest point table lookup: a load word appends (pressure, temperature, melt) to its
// composition's table unless that table is full or the composition is out of range; a
// query picks the dominant composition and scans that table through one read port and
// one shared distance unit, one entry per cycle; a query whose depth is not below the
// cutoff, or on an empty table, answers without a scan. One word is in flight at a time.
// Depends on npt_pkg, npt_in_if, npt_out_if, npt_store, npt_dist_unit.
module nearest_pt_table_lookup_core
    import npt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    npt_in_if.sink             in_ch,
    npt_out_if.source          out_ch,
    input  logic               cfg_we,
    input  logic [DEPTH_W-1:0] cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [DEPTH_W-1:0] cutoff_reg;
    logic [CNT_W-1:0]   counts_reg [NUM_COMPOSITIONS];

    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   issue_cnt_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [PRES_W-1:0]  qp_reg;
    logic [TEMP_W-1:0]  qt_reg;
    logic [COMP_W-1:0]  chosen_reg;
    logic               rd_vld_reg;

    logic               out_valid_reg;
    logic [MELT_W-1:0]  out_melt_reg;
    logic               out_found_reg;
    logic [COMP_W-1:0]  out_comp_reg;
    logic               out_full_reg;

    logic [FRAC_W-1:0]  frac [4];
    logic [FRAC_W-1:0]  best_frac;
    logic [COMP_W-1:0]  pick;
    logic [COMP_W-1:0]  sel_comp;
    logic [CNT_W-1:0]   cnt_sel;
    logic               out_free;
    logic               in_ready;
    logic               accept;
    logic               comp_ok;
    logic               is_full;
    logic               load_wr;
    logic               in_range;
    logic               start_scan;
    logic               rd_en;
    logic               scan_done;
    logic               out_load;
    logic [MELT_W-1:0]  res_melt;
    logic               res_found;
    logic [COMP_W-1:0]  res_comp;
    logic               res_full;
    entry_t             wr_ent;
    entry_t             rd_ent;
    dist_stat_t         dstat;

    assign frac[0] = in_ch.fraction_0;
    assign frac[1] = in_ch.fraction_1;
    assign frac[2] = in_ch.fraction_2;
    assign frac[3] = in_ch.fraction_3;

    always_comb
    begin
        best_frac = '0;
        pick      = '0;
        for (int c = 0; c < NUM_COMPOSITIONS && c < 4; c++)
        begin
            if (frac[c] > best_frac)
            begin
                best_frac = frac[c];
                pick      = COMP_W'(c);
            end
        end
    end

    assign sel_comp = (in_ch.opcode == OP_QUERY) ? pick : in_ch.load_composition;

    always_comb
    begin
        cnt_sel = '0;
        for (int c = 0; c < NUM_COMPOSITIONS; c++)
        begin
            if (32'(sel_comp) == c)
            begin
                cnt_sel = counts_reg[c];
            end
        end
    end

    assign out_free   = !out_valid_reg || out_ch.ready;
    assign in_ready   = (state_reg == S_IDLE) && out_free;
    assign accept     = in_ch.valid && in_ready;
    assign comp_ok    = 32'(in_ch.load_composition) < NUM_COMPOSITIONS;
    assign is_full    = cnt_sel >= CNT_W'(ENTRIES_PER_TABLE);
    assign load_wr    = accept && (in_ch.opcode == OP_LOAD) && comp_ok && !is_full;
    assign in_range   = in_ch.depth < cutoff_reg;
    assign start_scan = accept && (in_ch.opcode == OP_QUERY) && in_range && (cnt_sel != '0);

    assign rd_en     = (state_reg == S_SCAN) && (issue_cnt_reg != n_reg);
    assign scan_done = (state_reg == S_SCAN) && !rd_en && !rd_vld_reg && !dstat.busy;

    assign wr_ent.pres = in_ch.pressure;
    assign wr_ent.temp = in_ch.temperature;
    assign wr_ent.melt = in_ch.entry_melt;

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        res_melt   = '0;
        res_found  = 1'b0;
        res_comp   = '0;
        res_full   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.opcode == OP_LOAD)
                    begin
                        out_load = 1'b1;
                        res_comp = in_ch.load_composition;
                        res_full = comp_ok && is_full;
                    end
                    else if (!in_range)
                    begin
                        out_load = 1'b1;
                    end
                    else if (cnt_sel == '0)
                    begin
                        out_load = 1'b1;
                        res_comp = pick;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_done && out_free)
                begin
                    out_load   = 1'b1;
                    res_melt   = dstat.melt;
                    res_found  = dstat.found;
                    res_comp   = chosen_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cutoff_reg    <= CUTOFF_RESET;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            issue_cnt_reg <= '0;
            for (int c = 0; c < NUM_COMPOSITIONS; c++)
            begin
                counts_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_en;
            if (cfg_we)
            begin
                cutoff_reg <= cfg_wdata;
            end
            for (int c = 0; c < NUM_COMPOSITIONS; c++)
            begin
                if (load_wr && 32'(in_ch.load_composition) == c)
                begin
                    counts_reg[c] <= counts_reg[c] + CNT_W'(1);
                end
            end
            if (start_scan)
            begin
                issue_cnt_reg <= '0;
            end
            else if (rd_en)
            begin
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_scan)
        begin
            n_reg      <= cnt_sel;
            addr_reg   <= table_base(pick);
            qp_reg     <= in_ch.pressure;
            qt_reg     <= in_ch.temperature;
            chosen_reg <= pick;
        end
        else if (rd_en)
        begin
            addr_reg <= addr_reg + ADDR_W'(1);
        end
        if (out_load)
        begin
            out_melt_reg  <= res_melt;
            out_found_reg <= res_found;
            out_comp_reg  <= res_comp;
            out_full_reg  <= res_full;
        end
    end

    npt_store u_store (
        .clk     (clk),
        .we      (load_wr),
        .waddr   (table_base(in_ch.load_composition) + ADDR_W'(cnt_sel)),
        .wdata   (wr_ent),
        .re      (rd_en),
        .raddr   (addr_reg),
        .rd_data (rd_ent)
    );

    npt_dist_unit u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (start_scan),
        .ent_vld (rd_vld_reg),
        .ent     (rd_ent),
        .q_pres  (qp_reg),
        .q_temp  (qt_reg),
        .stat    (dstat)
    );

    assign in_ch.ready               = in_ready;
    assign out_ch.valid              = out_valid_reg;
    assign out_ch.melt_q16           = out_melt_reg;
    assign out_ch.found              = out_found_reg;
    assign out_ch.chosen_composition = out_comp_reg;
    assign out_ch.table_full         = out_full_reg;

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> n_reg != '0)
        else $error("scan running on an empty table");

    a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> state_reg == S_SCAN)
        else $error("read data outside a scan");

    a_found_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_found_reg |-> !out_full_reg)
        else $error("result flags both found and full");

    a_no_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> !load_wr && !start_scan)
        else $error("word taken during a scan");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        counts_reg[0] <= CNT_W'(ENTRIES_PER_TABLE))
        else $error("table fill count past its depth");

endmodule
